### hdl/sorted_value_list_engine_unit_assert.svh
// Assertion macros for the sorted value list engine.
`ifndef SORTED_VALUE_LIST_ENGINE_UNIT_ASSERT_SVH
`define SORTED_VALUE_LIST_ENGINE_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define SVLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SVLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/svle_pkg.sv
// Package: sizes, codes and item types of the sorted value list engine.
package svle_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = 5;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        value_t           operand_value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        count_t              entry_count;
        logic                store_empty;
        value_t              largest_value;
    } out_item_t;

    // Broadcast to every cell for the item being accepted.
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        value_t value;
    } cell_ctl_t;

    // What a cell shows its neighbours: contents and its insert-point flag.
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   ins_flag;
    } cell_link_t;

    // What a cell reports to the top level.
    typedef struct packed {
        logic   match;
        logic   nxt_valid;
        value_t nxt_value;
    } cell_stat_t;

endpackage

### hdl/svle_cell.sv
// One storage cell of the sorted chain: holds an entry, shifts right on insert, left on remove.
module svle_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  svle_pkg::cell_ctl_t  ctl,
    input  svle_pkg::cell_link_t left_link,
    input  svle_pkg::cell_link_t right_link,
    output svle_pkg::cell_link_t link,
    output svle_pkg::cell_stat_t stat
);

    svle_pkg::value_t value_reg;
    svle_pkg::value_t value_next;
    logic             valid_reg;
    logic             valid_next;
    logic             ins_here;
    logic             rm_here;

    // Insert point: first cell that is empty or holds a larger value.
    assign ins_here = !valid_reg || (ctl.value < value_reg);
    // Remove: every cell at or past the first value not below the operand pulls from the right.
    assign rm_here  = !valid_reg || !(value_reg < ctl.value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.ins_en)
        begin
            if (left_link.ins_flag)
            begin
                value_next = left_link.value;
                valid_next = left_link.valid;
            end
            else if (ins_here)
            begin
                value_next = ctl.value;
                valid_next = 1'b1;
            end
        end
        else if (ctl.rem_en && rm_here)
        begin
            value_next = right_link.value;
            valid_next = right_link.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value    = value_reg;
    assign link.valid    = valid_reg;
    assign link.ins_flag = ins_here;

    assign stat.match     = valid_reg && (value_reg == ctl.value);
    assign stat.nxt_valid = valid_next;
    assign stat.nxt_value = value_next;

endmodule

### hdl/sorted_value_list_engine_unit.sv
// Sorted value list engine: a row of shifting cells holding values in ascending order.
// The result of an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken.
// The output register frees whenever its result is taken, so a new item enters in that same cycle.
// Reset: rst_n clears the cell valid bits, the count and the output valid; entries are not cleared.
module sorted_value_list_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  svle_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output svle_pkg::out_item_t out_data
);

    svle_pkg::cell_ctl_t  ctl;
    svle_pkg::cell_link_t links [svle_pkg::DEPTH];
    svle_pkg::cell_link_t left_in [svle_pkg::DEPTH];
    svle_pkg::cell_link_t right_in [svle_pkg::DEPTH];
    svle_pkg::cell_stat_t stats [svle_pkg::DEPTH];

    logic [svle_pkg::DEPTH-1:0] match_vec;
    logic [svle_pkg::DEPTH-1:0] valid_vec;
    logic [svle_pkg::DEPTH-1:0] last_vec;

    svle_pkg::count_t    count_reg;
    svle_pkg::count_t    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    svle_pkg::out_item_t out_data_reg;
    svle_pkg::out_item_t out_data_next;

    logic             accept;
    logic             full;
    logic             found;
    svle_pkg::value_t largest;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == svle_pkg::count_t'(svle_pkg::DEPTH));
    assign found    = |match_vec;

    assign ctl.value  = in_data.operand_value;
    assign ctl.ins_en = accept && (in_data.command == svle_pkg::CMD_INSERT) && !full;
    assign ctl.rem_en = accept && (in_data.command == svle_pkg::CMD_REMOVE) && found;

    genvar i;
    generate
        for (i = 0; i < svle_pkg::DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign left_in[i] = '0;
            end
            else
            begin : g_mid
                assign left_in[i] = links[i-1];
            end

            if (i == svle_pkg::DEPTH - 1)
            begin : g_last
                assign right_in[i] = '0;
                assign last_vec[i] = stats[i].nxt_valid;
            end
            else
            begin : g_inner
                assign right_in[i] = links[i+1];
                assign last_vec[i] = stats[i].nxt_valid && !stats[i+1].nxt_valid;
            end

            svle_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_link  (left_in[i]),
                .right_link (right_in[i]),
                .link       (links[i]),
                .stat       (stats[i])
            );

            assign match_vec[i] = stats[i].match;
            assign valid_vec[i] = links[i].valid;
        end
    endgenerate

    // Largest entry after the update: the last valid cell of the next state, zero when empty.
    always_comb
    begin
        largest = '0;
        for (int k = 0; k < svle_pkg::DEPTH; k++)
        begin
            largest = largest | (stats[k].nxt_value & {svle_pkg::VALUE_WIDTH{last_vec[k]}});
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins_en)
        begin
            count_next = count_reg + svle_pkg::count_t'(1);
        end
        else if (ctl.rem_en)
        begin
            count_next = count_reg - svle_pkg::count_t'(1);
        end
    end

    always_comb
    begin
        out_data_next.entry_count   = count_next;
        out_data_next.store_empty   = (count_next == '0);
        out_data_next.largest_value = largest;
        unique case (in_data.command)
            svle_pkg::CMD_INSERT:
                out_data_next.status = full ? svle_pkg::ST_FULL : svle_pkg::ST_OK;
            svle_pkg::CMD_SEARCH,
            svle_pkg::CMD_REMOVE:
                out_data_next.status = found ? svle_pkg::ST_OK : svle_pkg::ST_NOT_FOUND;
            default:
                out_data_next.status = svle_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "sorted_value_list_engine_unit_assert.svh"

    `SVLE_ASSERT_ALWAYS(a_count_range, count_reg <= svle_pkg::count_t'(svle_pkg::DEPTH), "count beyond depth")
    `SVLE_ASSERT_ALWAYS(a_valid_count, $countones(valid_vec) == int'(count_reg), "cell valids disagree with count")
    `SVLE_ASSERT_ALWAYS(a_single_op, !(ctl.ins_en && ctl.rem_en), "insert and remove together")
    `SVLE_ASSERT_NEXT(a_full_refused, accept && in_data.command == svle_pkg::CMD_INSERT && full, out_data.status == svle_pkg::ST_FULL && $stable(count_reg), "insert into full store not refused")

endmodule

### verif/sorted_store_monitor.sv
// Monitor for the sorted value list engine: tracks the store, predicts and checks each result.
module sorted_store_monitor
    import svle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        error_count,
    output int        awaited_left
);
    timeunit 1ns;
    timeprecision 1ps;

    value_t    held [DEPTH];
    int        held_count = 0;
    out_item_t awaited [$];
    int        errors = 0;
    int        pending = 0;

    assign error_count  = errors;
    assign awaited_left = pending;

    // Applies one command to the tracked store and returns the result it should give.
    function automatic out_item_t apply_to_store(in_item_t it);
        out_item_t res;
        int        pos;
        int        k;
        res.status = ST_OK;
        pos = 0;
        case (it.command)
            CMD_INSERT: begin
                if (held_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    // a duplicate lands after its equals
                    while (pos < held_count && !(it.operand_value < held[pos]))
                        pos++;
                    for (k = held_count; k > pos; k--)
                        held[k] = held[k-1];
                    held[pos] = it.operand_value;
                    held_count++;
                end
            end
            CMD_SEARCH, CMD_REMOVE: begin
                while (pos < held_count && held[pos] != it.operand_value)
                    pos++;
                if (pos >= held_count)
                    res.status = ST_NOT_FOUND;
                else if (it.command == CMD_REMOVE)
                begin
                    for (k = pos; k + 1 < held_count; k++)
                        held[k] = held[k+1];
                    held_count--;
                end
            end
            default: ;  // unused code: store left alone, status ok
        endcase
        res.entry_count   = count_t'(held_count);
        res.store_empty   = (held_count == 0);
        res.largest_value = (held_count == 0) ? '0 : held[held_count-1];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            held_count = 0;
            awaited.delete();
            pending = 0;
        end
        else
        begin
            // results are registered after their item is accepted, so check before queuing this edge's item
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("unexpected result item %h with none awaited", out_data);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        errors++;
                    end
                    if (out_data.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_data.entry_count);
                        errors++;
                    end
                    if (out_data.store_empty !== want.store_empty)
                    begin
                        $error("store_empty: expected %0d, got %0d",
                               want.store_empty, out_data.store_empty);
                        errors++;
                    end
                    if (out_data.largest_value !== want.largest_value)
                    begin
                        $error("largest_value: expected %0d, got %0d",
                               want.largest_value, out_data.largest_value);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(apply_to_store(in_data));
            pending = awaited.size();
        end
    end

endmodule

### verif/tb.sv
// Testbench top: drives insert, search, remove and unused commands into the engine and gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import svle_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam int     RANDOM_ITEMS = 1820;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    int        error_count;
    int        awaited_left;

    int        send_idle_pct = 23;
    int        recv_idle_pct = 51;
    value_t    recent [8] = '{default: '0};
    int        recent_wr = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sorted_value_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sorted_store_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .error_count  (error_count),
        .awaited_left (awaited_left)
    );

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input value_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, operand_value: v};
        do
            @(posedge clk);
        while (!in_ready);
        if (cmd == CMD_INSERT)
        begin
            recent[recent_wr] = v;
            recent_wr = (recent_wr + 1) % 8;
        end
        @(negedge clk);
    endtask

    // Mostly a narrow band and recently inserted values so that searches and removes hit.
    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return value_t'(int'($urandom_range(0, 12)) - 6);
            4, 5:       return recent[$urandom_range(0, 7)];
            6: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return VAL_MIN + 1;
                    default: return VAL_MAX - 1;
                endcase
            end
            default:    return value_t'($urandom());
        endcase
    endfunction

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int                 n;
        int                 r;
        int                 k;
        int                 run_left;
        int                 waited;
        logic               filling;
        logic [CMD_W-1:0]   cmd;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty store cases
        send_item(CMD_SEARCH, 5);
        send_item(CMD_REMOVE, 5);
        send_item(CMD_UNUSED, -1);
        // a negative maximum, extremes and a duplicate
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, 0);
        send_item(CMD_SEARCH, VAL_MIN);
        send_item(CMD_SEARCH, VAL_MAX);
        send_item(CMD_SEARCH, 7);
        send_item(CMD_REMOVE, VAL_MAX);
        send_item(CMD_REMOVE, VAL_MIN);
        send_item(CMD_REMOVE, 7);
        // fill with falling values up to capacity, then push past it
        for (k = 0; k < 13; k++)
            send_item(CMD_INSERT, value_t'(100 - 17 * k));
        send_item(CMD_INSERT, 3);
        send_item(CMD_SEARCH, VAL_MAX);
        send_item(CMD_REMOVE, -1);

        filling  = 1'b1;
        run_left = $urandom_range(20, 60);
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 23;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (run_left == 0)
            begin
                filling  = !filling;
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            r = $urandom_range(0, 99);
            if (r < (filling ? 55 : 25))
                cmd = CMD_INSERT;
            else if (r < (filling ? 75 : 45))
                cmd = CMD_SEARCH;
            else if (r < 95)
                cmd = CMD_REMOVE;
            else
                cmd = CMD_UNUSED;
            send_item(cmd, pick_value());
        end
        in_valid <= 1'b0;

        waited = 0;
        while (awaited_left != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);

        if (error_count == 0 && awaited_left == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
